// ===== hw/rtl/pfe_pkg.sv =====
// Shared types, constants and the term exponent table of the polynomial evaluation unit.
`default_nettype none

package pfe_pkg;

	localparam int MAX_DEGREE  = 4;
	localparam int NUM_BANKS   = 2;
	localparam int NUM_VARS    = 5;
	localparam int VAR_W       = 24;
	localparam int COEF_W      = 32;
	localparam int FRAC        = 20;
	localparam int OUT_W       = 48;
	localparam int NUM_TERMS   = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) * (MAX_DEGREE + 3) *
		(MAX_DEGREE + 4) * (MAX_DEGREE + 5) / 120;
	localparam int STORE_DEPTH = NUM_BANKS * NUM_TERMS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TIDX_W      = $clog2(NUM_TERMS);
	localparam int EXP_W       = $clog2(MAX_DEGREE + 1);
	localparam int PW_W        = FRAC + MAX_DEGREE * (VAR_W - 1 - FRAC) + 2;
	localparam int PPROD_W     = VAR_W + PW_W;
	localparam int PROD_W      = 2 * PW_W;
	localparam int CPROD_W     = COEF_W + PW_W;
	localparam int TERM_W      = CPROD_W - FRAC;
	localparam int ACC_W       = TERM_W + $clog2(NUM_TERMS);
	localparam int PCNT_W      = $clog2(2 * MAX_DEGREE + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic signed [PW_W-1:0] ONE_Q =
		{{(PW_W - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};
	localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef logic [NUM_VARS-1:0][VAR_W-1:0] vars_t;
	typedef logic [NUM_VARS-1:0][EXP_W-1:0] exps_t;
	typedef logic [NUM_TERMS-1:0][NUM_VARS-1:0][EXP_W-1:0] exp_tab_t;

	typedef struct packed {
		logic              is_eval;
		logic [ADDR_W-1:0] addr;
		logic [COEF_W-1:0] coef;
		vars_t             vars;
	} pfe_item_t;

	typedef struct packed {
		logic  start;
		vars_t vars;
	} pfe_cmd_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		exps_t exps;
	} pfe_term_t;

	typedef struct packed {
		logic idle;
		logic pow_done;
	} pfe_stat_t;

	// Terms run by total degree, then by the z, y angle, y, x angle and x exponents.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		int       idx;
		tab = '0;
		idx = 0;
		for (int n = 0; n <= MAX_DEGREE; n++)
			for (int e = 0; e <= n; e++)
				for (int d = 0; d <= n; d++)
					for (int c = 0; c <= n; c++)
						for (int b = 0; b <= n; b++)
							for (int a = 0; a <= n; a++)
								if (a + b + c + d + e == n) begin
									tab[idx][0] = EXP_W'(a);
									tab[idx][1] = EXP_W'(b);
									tab[idx][2] = EXP_W'(c);
									tab[idx][3] = EXP_W'(d);
									tab[idx][4] = EXP_W'(e);
									idx++;
								end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/pfe_front.sv =====
// Front end: accepts items, drops loads to missing slots, resolves the bank and queues items.
`default_nettype none

module pfe_front import pfe_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     action,
	input  wire logic [7:0]               coef_index,
	input  wire logic signed [COEF_W-1:0] coef_value,
	input  wire logic signed [VAR_W-1:0]  var_x,
	input  wire logic signed [VAR_W-1:0]  var_xp,
	input  wire logic signed [VAR_W-1:0]  var_y,
	input  wire logic signed [VAR_W-1:0]  var_yp,
	input  wire logic signed [VAR_W-1:0]  var_z,
	input  wire logic                     bank,
	output pfe_item_t                     q_head,
	output logic                          q_valid,
	input  wire logic                     q_pop
);

	pfe_item_t         q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              keep;
	logic              push;
	logic              bank_eff;
	logic [ADDR_W-1:0] eval_base;
	pfe_item_t         item;

	always_comb begin
		busy      = (cnt_q == QCNT_W'(QDEPTH));
		keep      = (action == ACT_EVAL) || (int'(coef_index) < STORE_DEPTH);
		push      = start && !busy && keep;
		bank_eff  = (int'(bank) >= NUM_BANKS) ? 1'(NUM_BANKS - 1) : bank;
		eval_base = ADDR_W'(NUM_TERMS) * ADDR_W'(bank_eff);
		item.is_eval = (action == ACT_EVAL);
		item.addr    = (action == ACT_EVAL) ? eval_base : ADDR_W'(coef_index);
		item.coef    = coef_value;
		item.vars[0] = var_x;
		item.vars[1] = var_xp;
		item.vars[2] = var_y;
		item.vars[3] = var_yp;
		item.vars[4] = var_z;
		q_head  = q_mem_q[rd_ptr_q];
		q_valid = (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_back.sv =====
// Back-end sequencer: runs items from the queue, holds the coefficient store and issues terms.
`default_nettype none

module pfe_back import pfe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pfe_item_t            q_head,
	input  wire logic                 q_valid,
	output logic                      q_pop,
	input  wire pfe_stat_t            stat,
	output pfe_cmd_t                  cmd,
	output pfe_term_t                 term_s1,
	output logic signed [COEF_W-1:0]  coef_s1
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POW  = 2'd1;
	localparam logic [1:0] ST_TERM = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] base_q;
	logic [TIDX_W-1:0] tcnt_q;
	logic [COEF_W-1:0] mem_q [STORE_DEPTH];
	logic              wr_en;
	logic              t_last;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid && stat.idle;
		cmd.start = q_pop && q_head.is_eval;
		cmd.vars  = q_head.vars;
		wr_en     = q_pop && !q_head.is_eval;
		t_last    = (tcnt_q == TIDX_W'(NUM_TERMS - 1));
		rd_addr   = base_q + ADDR_W'(tcnt_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[q_head.addr] <= q_head.coef;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= '0;
			tcnt_q  <= '0;
			term_s1 <= '0;
		end else begin
			term_s1.valid <= (state_q == ST_TERM);
			term_s1.last  <= t_last;
			term_s1.exps  <= EXP_TAB[tcnt_q];
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						base_q  <= q_head.addr;
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					tcnt_q <= '0;
					if (stat.pow_done) begin
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					tcnt_q <= tcnt_q + 1'b1;
					if (t_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_mac.sv =====
// Power tables, monomial multiply pipeline, coefficient multiply, accumulator and saturation.
`default_nettype none

module pfe_mac import pfe_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pfe_cmd_t                 cmd,
	input  wire pfe_term_t                term_s1,
	input  wire logic signed [COEF_W-1:0] coef_s1,
	output pfe_stat_t                     stat,
	output logic                          done,
	output logic signed [OUT_W-1:0]       poly_value,
	output logic                          overflow
);

	localparam int NM = NUM_VARS - 1;

	typedef struct packed {
		logic              valid;
		logic              last;
		exps_t             exps;
		logic [COEF_W-1:0] coef;
	} tag_t;

	logic                      busy_q;
	logic                      pgen_q;
	logic                      pdone_q;
	logic [PCNT_W-1:0]         pcnt_q;
	logic [EXP_W-1:0]          pk;
	logic [VAR_W-1:0]          var_q   [NUM_VARS];
	logic signed [PW_W-1:0]    pcur_q  [NUM_VARS];
	logic signed [PPROD_W-1:0] pmul_q  [NUM_VARS];
	logic signed [PW_W-1:0]    prnd    [NUM_VARS];
	logic signed [PW_W-1:0]    pow_q   [NUM_VARS][MAX_DEGREE+1];

	tag_t                      tg_in   [1:NM];
	logic signed [PW_W-1:0]    m_in    [1:NM];
	tag_t                      tg_mq   [1:NM];
	tag_t                      tg_rq   [1:NM];
	logic signed [PROD_W-1:0]  mul_q   [1:NM];
	logic signed [PW_W-1:0]    m_q     [1:NM];
	tag_t                      tg_cq;
	tag_t                      tg_tq;
	logic signed [CPROD_W-1:0] cmul_q;
	logic signed [TERM_W-1:0]  term_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      fin_q;
	logic                      done_q;
	logic signed [OUT_W-1:0]   poly_value_q;
	logic                      overflow_q;
	logic                      ovf;
	logic signed [OUT_W-1:0]   sat;

	always_comb begin
		pk = EXP_W'(pcnt_q >> 1) + EXP_W'(1);
		for (int v = 0; v < NUM_VARS; v++) begin
			prnd[v] = pmul_q[v][FRAC +: PW_W] + PW_W'(pmul_q[v][FRAC-1]);
		end
		tg_in[1].valid = term_s1.valid;
		tg_in[1].last  = term_s1.last;
		tg_in[1].exps  = term_s1.exps;
		tg_in[1].coef  = coef_s1;
		m_in[1]        = pow_q[0][term_s1.exps[0]];
		for (int j = 2; j <= NM; j++) begin
			tg_in[j] = tg_rq[j-1];
			m_in[j]  = m_q[j-1];
		end
		ovf = !(&acc_q[ACC_W-1:OUT_W-1]) && (|acc_q[ACC_W-1:OUT_W-1]);
		sat = ovf ? (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc_q[OUT_W-1:0];
		stat.idle     = !busy_q;
		stat.pow_done = pdone_q;
		done       = done_q;
		poly_value = poly_value_q;
		overflow   = overflow_q;
	end

	// Powers of each variable: for each degree, a multiply step and then a rounding step.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int v = 0; v < NUM_VARS; v++) begin
				var_q[v]    <= cmd.vars[v];
				pcur_q[v]   <= ONE_Q;
				pow_q[v][0] <= ONE_Q;
			end
		end else if (pgen_q) begin
			for (int v = 0; v < NUM_VARS; v++) begin
				if (!pcnt_q[0]) begin
					pmul_q[v] <= PPROD_W'($signed(var_q[v])) * PPROD_W'(pcur_q[v]);
				end else begin
					pcur_q[v]    <= prnd[v];
					pow_q[v][pk] <= prnd[v];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 1; j <= NM; j++) begin
			mul_q[j] <= PROD_W'(m_in[j]) * PROD_W'(pow_q[j][tg_in[j].exps[j]]);
			m_q[j]   <= mul_q[j][FRAC +: PW_W] + PW_W'(mul_q[j][FRAC-1]);
		end
		cmul_q <= CPROD_W'($signed(tg_rq[NM].coef)) * CPROD_W'(m_q[NM]);
		term_q <= cmul_q[FRAC +: TERM_W] + TERM_W'(cmul_q[FRAC-1]);
		if (cmd.start) begin
			acc_q <= '0;
		end else if (tg_tq.valid) begin
			acc_q <= acc_q + ACC_W'(term_q);
		end
		if (fin_q) begin
			poly_value_q <= sat;
			overflow_q   <= ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pgen_q  <= 1'b0;
			pdone_q <= 1'b0;
			pcnt_q  <= '0;
			tg_cq   <= '0;
			tg_tq   <= '0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			for (int j = 1; j <= NM; j++) begin
				tg_mq[j] <= '0;
				tg_rq[j] <= '0;
			end
		end else begin
			if (cmd.start) begin
				busy_q  <= 1'b1;
				pgen_q  <= 1'b1;
				pdone_q <= 1'b0;
				pcnt_q  <= '0;
			end else begin
				if (pgen_q) begin
					pcnt_q <= pcnt_q + 1'b1;
					if (pcnt_q == PCNT_W'(2 * MAX_DEGREE - 1)) begin
						pgen_q  <= 1'b0;
						pdone_q <= 1'b1;
					end
				end
				if (fin_q) begin
					busy_q <= 1'b0;
				end
			end
			for (int j = 1; j <= NM; j++) begin
				tg_mq[j] <= tg_in[j];
				tg_rq[j] <= tg_mq[j];
			end
			tg_cq  <= tg_rq[NM];
			tg_tq  <= tg_cq;
			fin_q  <= tg_tq.valid && tg_tq.last;
			done_q <= fin_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/poly4_five_var_eval_unit.sv =====
// Top level of the five-variable degree-4 polynomial evaluation unit.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------------
//   item in   | start, busy        | action, coef_index, coef_value, var_x, var_xp,
//             |                    | var_y, var_yp, var_z, bank
//   result    | done (one cycle)   | poly_value, overflow
//
// The back end takes no new item until an evaluate item's result is out: it builds the powers,
// then the shared term pipeline takes one term per cycle; a load item is written as it is popped.
// A two-item queue sits between the front end and the back end; busy is high while it is full.
// Reset clears control state only; coefficients must be loaded before they are evaluated.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
`default_nettype none

module poly4_five_var_eval_unit import pfe_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     action,
	input  wire logic [7:0]               coef_index,
	input  wire logic signed [COEF_W-1:0] coef_value,
	input  wire logic signed [VAR_W-1:0]  var_x,
	input  wire logic signed [VAR_W-1:0]  var_xp,
	input  wire logic signed [VAR_W-1:0]  var_y,
	input  wire logic signed [VAR_W-1:0]  var_yp,
	input  wire logic signed [VAR_W-1:0]  var_z,
	input  wire logic                     bank,
	output logic                          done,
	output logic signed [OUT_W-1:0]       poly_value,
	output logic                          overflow
);

	pfe_item_t                q_head;
	logic                     q_valid;
	logic                     q_pop;
	pfe_stat_t                stat;
	pfe_cmd_t                 cmd;
	pfe_term_t                term_s1;
	logic signed [COEF_W-1:0] coef_s1;

	pfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.var_x      (var_x),
		.var_xp     (var_xp),
		.var_y      (var_y),
		.var_yp     (var_yp),
		.var_z      (var_z),
		.bank       (bank),
		.q_head     (q_head),
		.q_valid    (q_valid),
		.q_pop      (q_pop)
	);

	pfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.stat    (stat),
		.cmd     (cmd),
		.term_s1 (term_s1),
		.coef_s1 (coef_s1)
	);

	pfe_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.term_s1    (term_s1),
		.coef_s1    (coef_s1),
		.stat       (stat),
		.done       (done),
		.poly_value (poly_value),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire

// ===== bench/poly4_eval_checker.sv =====
// Checker for the polynomial evaluation unit: predicts each evaluate item's sum and compares results.
module poly4_eval_checker import pfe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     action,
	input  logic [7:0]               coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic signed [VAR_W-1:0]  var_x,
	input  logic signed [VAR_W-1:0]  var_xp,
	input  logic signed [VAR_W-1:0]  var_y,
	input  logic signed [VAR_W-1:0]  var_yp,
	input  logic signed [VAR_W-1:0]  var_z,
	input  logic                     bank,
	input  logic                     done,
	input  logic signed [OUT_W-1:0]  poly_value,
	input  logic                     overflow,
	output int                       mismatches,
	output int                       pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             ovf;
	} poly_sum_t;

	localparam wide_t UNIT_Q20 = 128'sd1 <<< FRAC;
	localparam wide_t HALF_LSB = 128'sd1 <<< (FRAC - 1);

	logic signed [COEF_W-1:0] coef_mem [STORE_DEPTH];
	int unsigned              term_exps [NUM_TERMS][NUM_VARS];
	poly_sum_t                expected_sums [$];
	int                       fail_count = 0;

	assign mismatches = fail_count;

	initial begin
		int t;
		t = 0;
		pending = 0;
		for (int i = 0; i < STORE_DEPTH; i++)
			coef_mem[i] = '0;
		for (int n = 0; n <= MAX_DEGREE; n++)
			for (int e = 0; e <= n; e++)
				for (int d = 0; d <= n; d++)
					for (int c = 0; c <= n; c++)
						for (int b = 0; b <= n; b++)
							for (int a = 0; a <= n; a++)
								if (a + b + c + d + e == n) begin
									term_exps[t][0] = a;
									term_exps[t][1] = b;
									term_exps[t][2] = c;
									term_exps[t][3] = d;
									term_exps[t][4] = e;
									t++;
								end
	end

	// Rounds a Q.20 scaled product back by twenty bits, halves going toward plus infinity.
	function automatic wide_t round_q20(input wide_t v);
		return (v + HALF_LSB) >>> FRAC;
	endfunction

	function automatic poly_sum_t poly_sum_q24(input vars_t v, input logic bk);
		wide_t                   pw [NUM_VARS][MAX_DEGREE+1];
		wide_t                   mono;
		wide_t                   acc;
		logic signed [VAR_W-1:0] s;
		poly_sum_t               r;
		int                      base;
		for (int i = 0; i < NUM_VARS; i++) begin
			s = v[i];
			pw[i][0] = UNIT_Q20;
			for (int k = 1; k <= MAX_DEGREE; k++)
				pw[i][k] = round_q20(pw[i][k-1] * wide_t'(s));
		end
		base = bk ? NUM_TERMS : 0;
		acc = '0;
		for (int t = 0; t < NUM_TERMS; t++) begin
			mono = pw[0][term_exps[t][0]];
			for (int i = 1; i < NUM_VARS; i++)
				mono = round_q20(mono * pw[i][term_exps[t][i]]);
			acc += round_q20(wide_t'(coef_mem[base + t]) * mono);
		end
		r.ovf = 1'b1;
		if (acc > wide_t'(SAT_MAX))
			acc = wide_t'(SAT_MAX);
		else if (acc < wide_t'(SAT_MIN))
			acc = wide_t'(SAT_MIN);
		else
			r.ovf = 1'b0;
		r.value = acc[OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		poly_sum_t want;
		if (arst_n) begin
			// A result at this edge always belongs to an item accepted earlier.
			if (done) begin
				if (expected_sums.size() == 0) begin
					$error("result with no evaluate item waiting: poly_value %0d, overflow %0b",
						poly_value, overflow);
					fail_count++;
				end else begin
					want = expected_sums.pop_front();
					if (poly_value !== want.value) begin
						$error("poly_value: expected %0d, actual %0d", $signed(want.value),
							poly_value);
						fail_count++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow: expected %0b, actual %0b", want.ovf, overflow);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				if (action == ACT_EVAL)
					expected_sums.push_back(poly_sum_q24({var_z, var_yp, var_y, var_xp, var_x},
						bank));
				else if (coef_index < STORE_DEPTH)
					coef_mem[coef_index] = coef_value;
			end
			pending <= expected_sums.size();
		end
	end

endmodule

// ===== bench/tb_poly4_five_var_eval_unit.sv =====
// Testbench top for the polynomial evaluation unit: clock, reset, item stimulus and verdict.
module tb_poly4_five_var_eval_unit;
	import pfe_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 500;
	localparam int RANDOM_ITEMS  = 110;
	localparam int SAT_TERMS     = 35;

	localparam logic signed [VAR_W-1:0]  VAR_MAX  = {1'b0, {(VAR_W - 1){1'b1}}};
	localparam logic signed [VAR_W-1:0]  VAR_MIN  = {1'b1, {(VAR_W - 1){1'b0}}};
	localparam logic signed [VAR_W-1:0]  VAR_ONE  = 24'sd1 <<< FRAC;
	localparam logic signed [VAR_W-1:0]  VAR_HALF = 24'sd1 <<< (FRAC - 1);
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_kind_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     action     = ACT_LOAD;
	logic [7:0]               coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic signed [VAR_W-1:0]  var_x      = '0;
	logic signed [VAR_W-1:0]  var_xp     = '0;
	logic signed [VAR_W-1:0]  var_y      = '0;
	logic signed [VAR_W-1:0]  var_yp     = '0;
	logic signed [VAR_W-1:0]  var_z      = '0;
	logic                     bank       = 1'b0;
	logic                     busy;
	logic                     done;
	logic signed [OUT_W-1:0]  poly_value;
	logic                     overflow;
	int                       mismatches;
	int                       pending;
	int                       stall_cycles = 0;
	bit                       quiet        = 1'b0;

	always #1 clk = ~clk;

	poly4_five_var_eval_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.var_x      (var_x),
		.var_xp     (var_xp),
		.var_y      (var_y),
		.var_yp     (var_yp),
		.var_z      (var_z),
		.bank       (bank),
		.done       (done),
		.poly_value (poly_value),
		.overflow   (overflow)
	);

	poly4_eval_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.var_x      (var_x),
		.var_xp     (var_xp),
		.var_y      (var_y),
		.var_yp     (var_yp),
		.var_z      (var_z),
		.bank       (bank),
		.done       (done),
		.poly_value (poly_value),
		.overflow   (overflow),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// The run is abandoned when neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic signed [VAR_W-1:0] rand_var();
		case ($urandom_range(5))
			0: return VAR_W'($urandom);
			1: return VAR_W'(int'($urandom_range(2 ** (FRAC + 1))) - 2 ** FRAC);
			2: begin
				case ($urandom_range(5))
					0: return VAR_MAX;
					1: return VAR_MIN;
					2: return VAR_ONE;
					3: return -VAR_ONE;
					4: return VAR_HALF;
					default: return '0;
				endcase
			end
			default: return VAR_W'($signed($urandom) >>> 9);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		case ($urandom_range(9))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return COEF_W'(int'($urandom_range(2 ** 25)) - 2 ** 24);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic put_item(input logic act, input logic [7:0] idx,
		input logic signed [COEF_W-1:0] cv, input logic signed [VAR_W-1:0] vx,
		input logic signed [VAR_W-1:0] vxp, input logic signed [VAR_W-1:0] vy,
		input logic signed [VAR_W-1:0] vyp, input logic signed [VAR_W-1:0] vz, input logic bk);
		while (!quiet && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		action     <= act;
		coef_index <= idx;
		coef_value <= cv;
		var_x      <= vx;
		var_xp     <= vxp;
		var_y      <= vy;
		var_yp     <= vyp;
		var_z      <= vz;
		bank       <= bk;
		start      <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_coef(input int slot, input logic signed [COEF_W-1:0] cv);
		put_item(ACT_LOAD, 8'(slot), cv, rand_var(), rand_var(), rand_var(), rand_var(),
			rand_var(), 1'($urandom));
	endtask

	task automatic evaluate(input logic signed [VAR_W-1:0] vx, input logic signed [VAR_W-1:0] vxp,
		input logic signed [VAR_W-1:0] vy, input logic signed [VAR_W-1:0] vyp,
		input logic signed [VAR_W-1:0] vz, input logic bk);
		put_item(ACT_EVAL, 8'($urandom), rand_coef(), vx, vxp, vy, vyp, vz, bk);
	endtask

	task automatic fill_bank(input int bk, input int first, input fill_kind_t kind);
		for (int t = first; t < NUM_TERMS; t++)
			case (kind)
				FILL_MAX: load_coef(bk * NUM_TERMS + t, COEF_MAX);
				FILL_MIN: load_coef(bk * NUM_TERMS + t, COEF_MIN);
				default:  load_coef(bk * NUM_TERMS + t, rand_coef());
			endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every coefficient is written before the first evaluate item.
		fill_bank(0, 0, FILL_RANDOM);
		fill_bank(1, 0, FILL_RANDOM);

		// Loads past the last slot must leave the store untouched; then two in-range loads and evaluates at edge values.
		load_coef(STORE_DEPTH, COEF_MAX);
		load_coef(255, COEF_MIN);
		load_coef(0, COEF_MAX);
		load_coef(NUM_TERMS - 1, COEF_MIN);
		evaluate('0, '0, '0, '0, '0, 1'b0);
		evaluate('0, '0, '0, '0, '0, 1'b1);
		evaluate(VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, 1'b0);
		evaluate(VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, 1'b1);
		evaluate(VAR_ONE, VAR_ONE, VAR_ONE, VAR_ONE, VAR_ONE, 1'b0);
		evaluate(-VAR_ONE, -VAR_ONE, -VAR_ONE, -VAR_ONE, -VAR_ONE, 1'b1);
		evaluate(VAR_HALF, -VAR_HALF, VAR_HALF, -VAR_HALF, VAR_HALF, 1'b0);
		evaluate(VAR_MAX, '0, '0, '0, '0, 1'b0);
		evaluate('0, '0, '0, '0, VAR_MIN, 1'b1);
		evaluate(VAR_MAX, VAR_MIN, VAR_MAX, VAR_MAX, VAR_MAX, 1'b0);
		evaluate(24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, 1'b1);

		// Saturation in both directions with the last top-degree coefficients at an extreme.
		fill_bank(1, NUM_TERMS - SAT_TERMS, FILL_MAX);
		evaluate(VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, 1'b1);
		evaluate(VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, 1'b1);
		fill_bank(1, NUM_TERMS - SAT_TERMS, FILL_MIN);
		evaluate(VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX, 1'b1);
		evaluate(VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, VAR_MIN, 1'b1);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 30 && i < 80);
			if ($urandom_range(99) < 55)
				evaluate(rand_var(), rand_var(), rand_var(), rand_var(), rand_var(),
					1'($urandom));
			else
				load_coef($urandom_range(255), rand_coef());
			if ($urandom_range(99) < 2)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_front.sv
hw/rtl/pfe_back.sv
hw/rtl/pfe_mac.sv
hw/rtl/poly4_five_var_eval_unit.sv
bench/poly4_eval_checker.sv
bench/tb_poly4_five_var_eval_unit.sv
